### sv/sm3_pkg.sv
`default_nettype none
package sm3_pkg;
    localparam int WordW = 32;
    localparam int QueueDepth = 4;
    localparam logic [31:0] TLow = 32'h79cc4519;
    localparam logic [31:0] THigh = 32'h7a879d8a;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [255:0] Iv = {32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
                                   32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } req_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction
endpackage
`default_nettype wire

### sv/sm3_queue.sv
`default_nettype none
module sm3_queue #(
    parameter int Depth = sm3_pkg::QueueDepth
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    output logic                in_ready,
    input  sm3_pkg::req_t       in_req,
    output logic                out_valid,
    input  wire                 out_ready,
    output sm3_pkg::req_t       out_req
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    sm3_pkg::req_t mem [Depth];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(Depth));
    assign out_valid = (cnt_reg != '0);
    assign out_req   = mem[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem[wr_reg] <= in_req;
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= (wr_reg == AW'(Depth-1)) ? '0 : wr_reg + 1'b1;
            if (pop)  rd_reg <= (rd_reg == AW'(Depth-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

### sv/sm3_core.sv
`default_nettype none
module sm3_core (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           req_valid,
    output logic          req_ready,
    input  sm3_pkg::req_t req,
    output logic          m_valid,
    input  wire           m_ready,
    output logic [31:0]   m_digest_word,
    output logic [2:0]    m_digest_index,
    output logic          m_last_digest
);
    localparam logic [2:0] S_IDLE = 3'd0, S_PUSH = 3'd1, S_ROUND = 3'd2,
                           S_FIN = 3'd3, S_OUT = 3'd4;

    logic [2:0]  state_reg;
    logic [31:0] buf_reg [16];
    logic [3:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [31:0] cv_reg [8];
    logic [31:0] r_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  rnd_reg;
    logic [31:0] pend_reg;
    logic [2:0]  phase_reg;
    logic [2:0]  oidx_reg;
    logic        msg_end_reg;

    logic [2:0]  cnt;
    logic [31:0] keep, word0, push_word;
    logic        push_en, go_out;
    logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2, wnext;

    always_comb begin
        cnt = (req.count > 3'd4) ? 3'd4 : req.count;
        keep = (cnt == 3'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {cnt, 3'b000}));
        word0 = (req.data & keep) |
                ({24'h0, sm3_pkg::PadByte} << (5'd24 - {cnt[1:0], 3'b000}));
    end

    // phase: 1 pending pad word, 2 zero fill then length high, 4 length low
    always_comb begin
        push_word = 32'h0;
        push_en = 1'b0;
        go_out = 1'b0;
        case (phase_reg)
            3'd1: begin push_word = pend_reg; push_en = 1'b1; end
            3'd2: begin
                push_en = 1'b1;
                if (fill_reg == 4'd14) begin
                    push_word = bits_reg[63:32];
                end
            end
            3'd4: begin push_word = bits_reg[31:0]; push_en = 1'b1; end
            default: go_out = 1'b1;
        endcase
    end

    always_comb begin
        a12 = sm3_pkg::rotl(r_reg[0], 5'd12);
        tj = sm3_pkg::rotl((rnd_reg < 6'd16) ? sm3_pkg::TLow : sm3_pkg::THigh, rnd_reg[4:0]);
        ss1 = sm3_pkg::rotl(a12 + r_reg[4] + tj, 5'd7);
        ss2 = ss1 ^ a12;
        if (rnd_reg < 6'd16) begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end else begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ff + r_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + r_reg[7] + ss1 + w_reg[0];
        wnext = sm3_pkg::p1(w_reg[0] ^ w_reg[7] ^ sm3_pkg::rotl(w_reg[13], 5'd15)) ^
                sm3_pkg::rotl(w_reg[3], 5'd7) ^ w_reg[10];
    end

    assign req_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_digest_word = cv_reg[oidx_reg];
    assign m_digest_index = oidx_reg;
    assign m_last_digest = (oidx_reg == 3'd7);

    task automatic store(input logic [31:0] wd);
        buf_reg[fill_reg] <= wd;
        fill_reg <= fill_reg + 1'b1;
        if (fill_reg == 4'd15) begin
            state_reg <= S_ROUND;
            rnd_reg <= '0;
            for (int k = 0; k < 15; k++) w_reg[k] <= buf_reg[k];
            w_reg[15] <= wd;
            for (int k = 0; k < 8; k++) r_reg[k] <= cv_reg[k];
        end
    endtask

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            bits_reg <= '0;
            phase_reg <= '0;
            oidx_reg <= '0;
            for (int k = 0; k < 8; k++) cv_reg[k] <= sm3_pkg::Iv[255-32*k -: 32];
        end else begin
            case (state_reg)
                S_IDLE: if (req_valid) begin
                    if (!req.last) begin
                        bits_reg <= bits_reg + 64'd32;
                        phase_reg <= 3'd0;
                        store(req.data);
                    end else begin
                        bits_reg <= bits_reg + {58'h0, cnt, 3'b000};
                        pend_reg <= {sm3_pkg::PadByte, 24'h0};
                        phase_reg <= (cnt == 3'd4) ? 3'd1 : 3'd2;
                        state_reg <= S_PUSH;
                        store((cnt == 3'd4) ? req.data : word0);
                    end
                end
                S_PUSH: begin
                    if (go_out) begin
                        state_reg <= S_OUT;
                        oidx_reg <= '0;
                    end else begin
                        if (phase_reg == 3'd1) phase_reg <= 3'd2;
                        else if (phase_reg == 3'd2 && fill_reg == 4'd14) phase_reg <= 3'd4;
                        else if (phase_reg == 3'd4) phase_reg <= 3'd0;
                        if (push_en) store(push_word);
                    end
                end
                S_ROUND: begin
                    r_reg[3] <= r_reg[2];
                    r_reg[2] <= sm3_pkg::rotl(r_reg[1], 5'd9);
                    r_reg[1] <= r_reg[0];
                    r_reg[0] <= tt1;
                    r_reg[7] <= r_reg[6];
                    r_reg[6] <= sm3_pkg::rotl(r_reg[5], 5'd19);
                    r_reg[5] <= r_reg[4];
                    r_reg[4] <= sm3_pkg::p0(tt2);
                    for (int k = 0; k < 15; k++) w_reg[k] <= w_reg[k+1];
                    w_reg[15] <= wnext;
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    for (int k = 0; k < 8; k++) cv_reg[k] <= cv_reg[k] ^ r_reg[k];
                    state_reg <= (phase_reg == 3'd0 && !msg_end_reg) ? S_IDLE : S_PUSH;
                end
                S_OUT: if (m_ready) begin
                    oidx_reg <= oidx_reg + 1'b1;
                    if (oidx_reg == 3'd7) begin
                        state_reg <= S_IDLE;
                        bits_reg <= '0;
                        fill_reg <= '0;
                        for (int k = 0; k < 8; k++) cv_reg[k] <= sm3_pkg::Iv[255-32*k -: 32];
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) msg_end_reg <= 1'b0;
        else if (state_reg == S_IDLE && req_valid) msg_end_reg <= req.last;
    end
endmodule
`default_nettype wire

### sv/sm3_hash_engine.sv
`default_nettype none
// SM3 hash engine.
// Input channel s_*: one big-endian message word per request; s_byte_count
// gives the valid bytes (0..4) and matters only on the request with s_last_word.
// Output channel m_*: eight digest words per message, index 0 first, the
// eighth marked by m_last_digest.
// Requests enter a four-entry queue, so the sender can run ahead of the core.
// The core takes one word per cycle while idle. A word that fills a 16-word block starts
// 64 compression rounds at one round per cycle and then a fold into the chaining value;
// no word is taken meanwhile, so the single round unit sets the sustained rate.
// The last word adds padding at one word per cycle, one or two compressions,
// then the digest words, one per cycle while m_ready is high.
// When the receiver stalls, the current digest word holds and the core waits;
// the queue keeps taking requests until it is full.
// Reset (aresetn low, synchronous) empties the queue, clears the length and
// fill count and loads the standard initial value; the block is ready at once.
module sm3_hash_engine #(
    parameter int QueueDepth = sm3_pkg::QueueDepth
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [31:0] s_data_word,
    input  wire  [2:0]  s_byte_count,
    input  wire         s_last_word,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_digest_index,
    output logic        m_last_digest
);
    sm3_pkg::req_t in_req, q_req;
    logic q_valid, q_ready;

    assign in_req = '{data: s_data_word, count: s_byte_count, last: s_last_word};

    sm3_queue #(.Depth(QueueDepth)) u_queue (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .in_req(in_req),
        .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
    );

    sm3_core u_core (
        .aclk, .aresetn,
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .m_valid, .m_ready, .m_digest_word, .m_digest_index, .m_last_digest
    );

    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_digest == (m_digest_index == 3'd7)))
        else $error("last flag mismatch");
    a_idx_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_digest) |=> (m_valid &&
            m_digest_index == $past(m_digest_index) + 3'd1))
        else $error("digest index skipped");
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !q_ready)
        else $error("core took request while emitting");
endmodule
`default_nettype wire

### dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] IvWords [8] = '{32'h7380166f, 32'h4914b2b9, 32'h172442d7,
        32'hda8a0600, 32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
    localparam int CycleLimit = 2000000;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_t;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  count;
        logic        last;
    } request_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data_word = '0;
    logic [2:0]  s_byte_count = '0;
    logic        s_last_word = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_digest_index;
    logic        m_last_digest;

    logic [31:0] chain [8];
    logic [31:0] blk [16];
    int unsigned fill;
    logic [63:0] msg_bits;
    digest_t     digest_q [$];
    request_t    dir_q [$];
    int          errors = 0;
    int          cycles = 0;
    bit          hold_rx = 1'b0;

    sm3_hash_engine i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_word(s_data_word),
        .s_byte_count(s_byte_count), .s_last_word(s_last_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_digest_word(m_digest_word),
        .m_digest_index(m_digest_index), .m_last_digest(m_last_digest)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [31:0] rl(logic [31:0] x, int n);
        n = n % 32;
        return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
    endfunction

    task automatic compress();
        logic [31:0] w [16];
        logic [31:0] r [8];
        logic [31:0] nxt, a12, tj, ss1, ss2, ff, gg, tt1, tt2, t;
        for (int k = 0; k < 16; k++) w[k] = blk[k];
        for (int k = 0; k < 8; k++) r[k] = chain[k];
        for (int j = 0; j < 64; j++) begin
            t = w[0] ^ w[7] ^ rl(w[13], 15);
            nxt = t ^ rl(t, 15) ^ rl(t, 23) ^ rl(w[3], 7) ^ w[10];
            a12 = rl(r[0], 12);
            tj = (j < 16) ? rl(32'h79cc4519, j) : rl(32'h7a879d8a, j);
            ss1 = rl(a12 + r[4] + tj, 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = r[0] ^ r[1] ^ r[2];
                gg = r[4] ^ r[5] ^ r[6];
            end else begin
                ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                gg = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            tt1 = ff + r[3] + ss2 + (w[0] ^ w[4]);
            tt2 = gg + r[7] + ss1 + w[0];
            r[3] = r[2]; r[2] = rl(r[1], 9); r[1] = r[0]; r[0] = tt1;
            r[7] = r[6]; r[6] = rl(r[5], 19); r[5] = r[4];
            r[4] = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
            for (int k = 0; k < 15; k++) w[k] = w[k + 1];
            w[15] = nxt;
        end
        for (int k = 0; k < 8; k++) chain[k] ^= r[k];
    endtask

    task automatic push_block_word(logic [31:0] word);
        blk[fill] = word;
        fill++;
        if (fill >= 16) begin
            compress();
            fill = 0;
        end
    endtask

    task automatic hash_reset();
        for (int k = 0; k < 8; k++) chain[k] = IvWords[k];
        fill = 0;
        msg_bits = '0;
    endtask

    task automatic predict_digest(request_t rq);
        int unsigned c;
        logic [31:0] keep;
        digest_t d;
        if (!rq.last) begin
            msg_bits += 64'd32;
            push_block_word(rq.data);
            return;
        end
        c = (rq.count > 4) ? 4 : rq.count;
        msg_bits += 64'(c * 8);
        if (c == 4) begin
            push_block_word(rq.data);
            push_block_word(32'h80000000);
        end else begin
            keep = (c == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * c));
            push_block_word((rq.data & keep) | (32'h80 << (24 - 8 * c)));
        end
        if (fill > 14) while (fill != 0) push_block_word('0);
        while (fill < 14) push_block_word('0);
        push_block_word(msg_bits[63:32]);
        push_block_word(msg_bits[31:0]);
        for (int k = 0; k < 8; k++) begin
            d.word = chain[k];
            d.index = 3'(k);
            d.last = (k == 7);
            digest_q.push_back(d);
        end
        hash_reset();
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task automatic send(request_t rq);
        s_data_word <= rq.data;
        s_byte_count <= rq.count;
        s_last_word <= rq.last;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_digest(rq);
        @(negedge aclk);
    endtask

    task automatic idle(int n);
        if (n > 0) begin
            if (s_valid) s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        digest_t d;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("[sm3_hash_engine] ERROR");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                report("unexpected digest", m_digest_word, 32'h0);
            end else begin
                d = digest_q.pop_front();
                if (m_digest_word !== d.word) report("digest_word", m_digest_word, d.word);
                if (m_digest_index !== d.index)
                    report("digest_index", 32'(m_digest_index), 32'(d.index));
                if (m_last_digest !== d.last)
                    report("last_digest", 32'(m_last_digest), 32'(d.last));
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_rx) m_ready <= 1'b0;
        else case (cycles % 97 < 40 ? 0 : (cycles % 97 < 60 ? 1 : 2))
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    function automatic request_t mk(logic [31:0] d, logic [2:0] c, logic l);
        request_t r;
        r.data = d; r.count = c; r.last = l;
        return r;
    endfunction

    initial begin
        request_t rq;
        int burst, len;
        hash_reset();
        // empty message, short tails, overlong counts, full-block boundaries
        dir_q.push_back(mk(32'hffffffff, 3'd0, 1'b1));
        dir_q.push_back(mk(32'h61626300, 3'd3, 1'b1));
        dir_q.push_back(mk(32'hffffffff, 3'd1, 1'b1));
        dir_q.push_back(mk(32'hffffffff, 3'd2, 1'b1));
        dir_q.push_back(mk(32'h00000000, 3'd4, 1'b1));
        dir_q.push_back(mk(32'hffffffff, 3'd7, 1'b1));
        dir_q.push_back(mk(32'h12345678, 3'd5, 1'b1));
        dir_q.push_back(mk(32'haaaaaaaa, 3'd1, 1'b0));
        dir_q.push_back(mk(32'h55555555, 3'd6, 1'b0));
        dir_q.push_back(mk(32'hdeadbeef, 3'd0, 1'b1));
        for (int k = 0; k < 13; k++) dir_q.push_back(mk(32'(k) * 32'h01010101, 3'd4, 1'b0));
        dir_q.push_back(mk(32'hcafef00d, 3'd4, 1'b1));
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (dir_q[i]) send(dir_q[i]);
        for (int n = 0; n < 500; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                burst = $urandom_range(0, 12);
                idle(burst);
            end
            if (n == 250) begin
                hold_rx = 1'b1;
                idle(30);
                hold_rx = 1'b0;
                while (digest_q.size() != 0) @(negedge aclk);
            end
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 8);
            rq.data = $urandom;
            rq.count = 3'($urandom_range(0, 7));
            rq.last = ($urandom_range(0, len) == 0);
            send(rq);
        end
        rq = mk($urandom, 3'($urandom_range(0, 4)), 1'b1);
        send(rq);
        idle(1);
        while (digest_q.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (errors == 0 && digest_q.size() == 0) begin
            $display("[sm3_hash_engine] OK");
        end else begin
            $display("[sm3_hash_engine] ERROR");
        end
        $finish;
    end
endmodule
